// ----- sv/assert_macros.svh -----
// Assertion macros for the RTL, included by mt19937_bounded_random.sv.
// Define ASSERT_OFF to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error("assertion failed");
`define ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("assertion failed");
`else
`define ASSERT_IMP(label, ante, cons)
`define ASSERT_NXT(label, ante, cons)
`endif
`endif

// ----- sv/mtbr_pkg.sv -----
// Package for the MT19937 bounded random block: constants, types, tempering.
// No dependencies.
`timescale 1ns / 1ps
package mtbr_pkg;
	localparam int STATE_WORDS = 624;
	localparam int TWIST_OFFSET = 397;
	localparam int IDX_W = 10;
	localparam logic [31:0] TWIST_MATRIX = 32'h9908b0df;
	localparam logic [31:0] INIT_MULT = 32'd1812433253;
	localparam logic [31:0] DEFAULT_SEED = 32'd5489;
	localparam logic [31:0] TEMPER_B = 32'h9d2c5680;
	localparam logic [31:0] TEMPER_C = 32'hefc60000;
	localparam logic [31:0] KEEP_SEED = 32'hffffffff;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(STATE_WORDS - 1);
	localparam logic [IDX_W-1:0] FULL_IDX = IDX_W'(STATE_WORDS);
	localparam logic [IDX_W-1:0] UNSEEDED = IDX_W'(STATE_WORDS + 1);
	localparam logic [IDX_W-1:0] FAR_WRAP = IDX_W'(STATE_WORDS - TWIST_OFFSET);
	localparam logic KIND_DRAW = 1'b0;
	localparam logic KIND_SEED = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE, ST_SEED_RD, ST_SEED_MUL, ST_SEED_WR,
		ST_TW_RD0, ST_TW_RD1, ST_TW_RD2, ST_TW_WR,
		ST_FETCH, ST_FETCH_W, ST_DIV, ST_OUT
	} state_t;

	typedef struct packed {
		logic start;
		logic busy;
	} div_ctl_t;

	function automatic logic [31:0] temper(input logic [31:0] x);
		logic [31:0] y;
		y = x ^ (x >> 11);
		y = y ^ ((y << 7) & TEMPER_B);
		y = y ^ ((y << 15) & TEMPER_C);
		y = y ^ (y >> 18);
		return y;
	endfunction
endpackage

// ----- sv/mtbr_div.sv -----
// Restoring radix-2 remainder unit, one quotient bit per cycle.
// Depends on mtbr_pkg.
`timescale 1ns / 1ps
module mtbr_div import mtbr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] dividend,
	input  logic [31:0] divisor,
	output div_ctl_t    ctl,
	output logic [31:0] remainder
);
	logic [31:0] num_q, den_q, rem_q;
	logic [5:0]  cnt_q;
	logic        busy_q;
	logic [32:0] trial;
	logic [32:0] shifted;

	assign shifted = {rem_q, num_q[31]};
	assign trial = shifted - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q <= 6'd32;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 6'd1;
			if (cnt_q == 6'd1) busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			den_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[30:0], 1'b0};
			rem_q <= trial[32] ? shifted[31:0] : trial[31:0];
		end
	end

	assign ctl.start = start;
	assign ctl.busy = busy_q;
	assign remainder = rem_q;
endmodule

// ----- sv/mt19937_bounded_random.sv -----
// MT19937 bounded random generator. A draw reads the next state word, tempers it and returns
// its remainder modulo the bound from the serial remainder unit (bound <= 1: result 0 directly).
// A twist of all 624 words runs first when the index runs out; a reseed rewrites all 624 words.
// The block takes one item at a time, set by the serial remainder unit and the single state
// memory port. A draw before any seed first seeds with 5489, then twists.
// Reset (arst_n, async low) clears control and marks the state unseeded; memory is not cleared.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module mt19937_bounded_random import mtbr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // bound[31:0], seed_value[63:32]
	input  logic        s_tuser,   // kind
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata    // random_value[31:0]
);
	logic [31:0] mem [STATE_WORDS];
	logic [31:0] rd_q;
	state_t state_q, state_d;
	logic [IDX_W-1:0] idx_q, k_q, addr;
	logic [31:0] bound_q, prev_q, yk_q, ynx_q, res_q, wdata;
	logic [31:0] prod_s1;
	logic kind_q;
	logic we, m_valid_q, div_start;
	div_ctl_t dctl;
	logic [31:0] rem;
	logic [IDX_W-1:0] k_nxt, k_far;
	logic [31:0] y_mix, tw_w;

	assign k_nxt = (k_q == LAST_IDX) ? '0 : k_q + IDX_W'(1);
	assign k_far = (k_q >= FAR_WRAP) ? k_q - FAR_WRAP : k_q + IDX_W'(TWIST_OFFSET);
	assign y_mix = {yk_q[31], ynx_q[30:0]};
	assign tw_w = rd_q ^ (y_mix >> 1) ^ (y_mix[0] ? TWIST_MATRIX : 32'd0);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (s_tvalid) begin
				if (s_tuser == KIND_SEED)
					state_d = (s_tdata[63:32] == KEEP_SEED) ? ST_IDLE : ST_SEED_RD;
				else if (s_tdata[31:0] <= 32'd1) state_d = ST_OUT;
				else if (idx_q == UNSEEDED) state_d = ST_SEED_RD;
				else if (idx_q == FULL_IDX) state_d = ST_TW_RD0;
				else state_d = ST_FETCH;
			end
			ST_SEED_RD: state_d = ST_SEED_MUL;
			// a draw that forced the default seed goes on to the twist
			ST_SEED_WR: if (k_q == LAST_IDX)
					state_d = (kind_q == KIND_SEED) ? ST_IDLE : ST_TW_RD0;
				else state_d = ST_SEED_MUL;
			ST_SEED_MUL: state_d = ST_SEED_WR;
			ST_TW_RD0: state_d = ST_TW_RD1;
			ST_TW_RD1: state_d = ST_TW_RD2;
			ST_TW_RD2: state_d = ST_TW_WR;
			ST_TW_WR: state_d = (k_q == LAST_IDX) ? ST_FETCH : ST_TW_RD0;
			ST_FETCH: state_d = ST_FETCH_W;
			ST_FETCH_W: state_d = ST_DIV;
			ST_DIV: if (!dctl.busy && !dctl.start) state_d = ST_OUT;
			ST_OUT: if (m_tready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		addr = k_q;
		we = 1'b0;
		wdata = prod_s1 + {{(32-IDX_W){1'b0}}, k_q};
		div_start = 1'b0;
		case (state_q)
			ST_SEED_RD: begin
				we = 1'b1;
				wdata = prev_q;
			end
			ST_SEED_WR: we = 1'b1;
			ST_TW_RD0: addr = k_q;
			ST_TW_RD1: addr = k_nxt;
			ST_TW_RD2: addr = k_far;
			ST_TW_WR: begin
				we = 1'b1;
				wdata = tw_w;
			end
			ST_FETCH: addr = idx_q;
			ST_FETCH_W: div_start = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) mem[addr] <= wdata;
		rd_q <= mem[addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q <= UNSEEDED;
			k_q <= '0;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_IDLE: begin
					k_q <= '0;
					if (s_tvalid && state_d == ST_OUT) m_valid_q <= 1'b1;
				end
				ST_SEED_RD: k_q <= IDX_W'(1);
				ST_SEED_WR: begin
					k_q <= k_q + IDX_W'(1);
					if (k_q == LAST_IDX) begin
						k_q <= '0;
						idx_q <= FULL_IDX;
					end
				end
				ST_TW_WR: begin
					k_q <= k_nxt;
					if (k_q == LAST_IDX) idx_q <= '0;
				end
				ST_FETCH: idx_q <= idx_q + IDX_W'(1);
				ST_DIV: if (state_d == ST_OUT) m_valid_q <= 1'b1;
				ST_OUT: if (m_tready) m_valid_q <= 1'b0;
				default: ;
			endcase
		end
	end

	// seed path: ST_SEED_RD writes word 0, then prev_q feeds the multiplier
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: if (s_tvalid) begin
				bound_q <= s_tdata[31:0];
				res_q <= '0;
				kind_q <= s_tuser;
				prev_q <= (s_tuser == KIND_SEED) ? s_tdata[63:32] : DEFAULT_SEED;
			end
			ST_SEED_MUL: prod_s1 <= INIT_MULT * (prev_q ^ (prev_q >> 30));
			ST_SEED_WR: prev_q <= wdata;
			ST_TW_RD1: yk_q <= rd_q;
			ST_TW_RD2: ynx_q <= rd_q;
			ST_DIV: if (state_d == ST_OUT) res_q <= rem;
			default: ;
		endcase
	end

	mtbr_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.dividend(temper(rd_q)), .divisor(bound_q), .ctl(dctl), .remainder(rem)
	);

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_valid_q;
	assign m_tdata = res_q;

	`ASSERT_IMP(a_out_only_in_out, m_tvalid, state_q == ST_OUT)
	`ASSERT_IMP(a_no_accept_busy, dctl.busy, !s_tready)
	`ASSERT_NXT(a_idx_range, s_tvalid && s_tready, idx_q <= UNSEEDED)
endmodule

// ----- sim/mt19937_bounded_random_checker.sv -----
// Checker for the MT19937 bounded random block: watches both streams,
// predicts each draw with its own twister copy and compares. Depends on mtbr_pkg.
`timescale 1ns / 1ps
module mt19937_bounded_random_checker import mtbr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [63:0] s_tdata,
	input  logic        s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [31:0] m_tdata,
	output int          fail_count,
	output int          pending
);
	logic [31:0] mt_words [STATE_WORDS];
	int unsigned mt_index;
	logic [31:0] draw_q [$];

	assign pending = draw_q.size();

	task automatic mt_seed(input logic [31:0] s);
		logic [31:0] p;
		mt_words[0] = s;
		for (int i = 1; i < STATE_WORDS; i++) begin
			p = mt_words[i-1];
			mt_words[i] = 32'd1812433253 * (p ^ (p >> 30)) + 32'(i);
		end
		mt_index = STATE_WORDS;
	endtask

	task automatic mt_twist();
		logic [31:0] y, w;
		for (int k = 0; k < STATE_WORDS; k++) begin
			y = (mt_words[k] & 32'h80000000) | (mt_words[(k+1) % STATE_WORDS] & 32'h7fffffff);
			w = mt_words[(k + TWIST_OFFSET) % STATE_WORDS] ^ (y >> 1);
			if (y[0])
				w = w ^ 32'h9908b0df;
			mt_words[k] = w;
		end
		mt_index = 0;
	endtask

	function automatic logic [31:0] mt_temper(input logic [31:0] x);
		logic [31:0] y;
		y = x ^ (x >> 11);
		y = y ^ ((y << 7) & 32'h9d2c5680);
		y = y ^ ((y << 15) & 32'hefc60000);
		return y ^ (y >> 18);
	endfunction

	task automatic predict_item(input logic kind, input logic [31:0] bound,
			input logic [31:0] seed);
		logic [31:0] y;
		if (kind == KIND_SEED) begin
			if (seed != KEEP_SEED)
				mt_seed(seed);
		end else if (bound <= 32'd1) begin
			draw_q.push_back(32'd0);
		end else begin
			if (mt_index >= STATE_WORDS) begin
				if (mt_index == STATE_WORDS + 1)
					mt_seed(DEFAULT_SEED);
				mt_twist();
			end
			y = mt_temper(mt_words[mt_index]);
			mt_index++;
			draw_q.push_back(y % bound);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mt_index = STATE_WORDS + 1;
			fail_count <= 0;
			draw_q.delete();
		end else begin
			if (s_tvalid && s_tready)
				predict_item(s_tuser, s_tdata[31:0], s_tdata[63:32]);
			if (m_tvalid && m_tready) begin
				if (draw_q.size() == 0) begin
					if (fail_count < 10)
						$display("unexpected transfer: random_value=%h", m_tdata);
					fail_count <= fail_count + 1;
				end else begin
					if (draw_q[0] !== m_tdata) begin
						if (fail_count < 10)
							$display("mismatch: random_value exp=%h got=%h", draw_q[0], m_tdata);
						fail_count <= fail_count + 1;
					end
					void'(draw_q.pop_front());
				end
			end
		end
	end
endmodule

// ----- sim/mt19937_bounded_random_tb.sv -----
// Testbench top for mt19937_bounded_random: drives draws and reseeds with
// random gaps and stalls, gives the verdict. Depends on the DUT, the checker module and mtbr_pkg.
`timescale 1ns / 1ps
module mt19937_bounded_random_tb import mtbr_pkg::*;;
	logic clk = 0;
	logic arst_n = 0;
	logic s_tvalid = 0, s_tready, s_tuser = 0;
	logic [63:0] s_tdata = 0;
	logic m_tvalid, m_tready = 0;
	logic [31:0] m_tdata;
	int fail_count, pending;
	bit calm = 0;
	bit hold_off = 0;

	always #4 clk = ~clk;

	mt19937_bounded_random dut (.*);
	mt19937_bounded_random_checker chk (.*);

	function automatic logic [31:0] pick_bound();
		case ($urandom_range(0, 9))
			0: return $urandom_range(0, 1);
			1: return 32'hffffffff - $urandom_range(0, 3);
			2: return 32'h80000000 + $urandom_range(0, 1);
			3, 4: return $urandom();
			default: return $urandom_range(2, 1000);
		endcase
	endfunction

	// idle on the input side: drops s_tvalid and waits for a clock edge
	task automatic rest();
		s_tvalid <= 0;
		@(posedge clk);
	endtask

	task automatic send(input logic kind, input logic [31:0] bound, input logic [31:0] seed);
		while (!calm && $urandom_range(0, 99) < 22)
			rest();
		s_tvalid <= 1;
		s_tuser <= kind;
		s_tdata <= {seed, bound};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	// receiver: random stalls, or a long hold-off when asked
	always @(posedge clk) begin
		if (hold_off)
			m_tready <= 0;
		else
			m_tready <= calm || ($urandom_range(0, 99) >= 22);
	end

	initial begin
		int wait_cycles;
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// draw before any seed uses the default seed
		send(KIND_DRAW, 32'hffffffff, 32'hffffffff);
		send(KIND_DRAW, 32'd0, $urandom());
		send(KIND_DRAW, 32'd1, 32'h0);
		send(KIND_DRAW, 32'd2, 32'h0);
		send(KIND_SEED, 32'hffffffff, 32'hffffffff);
		send(KIND_DRAW, 32'h80000000, 32'h0);
		send(KIND_SEED, 32'h0, 32'h0);
		send(KIND_DRAW, 32'hffffffff, 32'h0);
		send(KIND_SEED, 32'h0, 32'hfffffffe);
		send(KIND_DRAW, 32'h7fffffff, 32'h0);
		send(KIND_SEED, 32'hffffffff, 32'h12345678);
		send(KIND_SEED, 32'h0, 32'hffffffff);
		send(KIND_DRAW, 32'd3, 32'hffffffff);
		// long receiver hold-off while the sender keeps offering
		fork
			begin
				hold_off = 1;
				repeat (400) @(posedge clk);
				hold_off = 0;
			end
			begin
				for (int i = 0; i < 6; i++)
					send(KIND_DRAW, $urandom_range(2, 100), 32'h0);
				rest();
			end
		join
		for (int n = 0; n < 800; n++) begin
			calm = (n >= 300 && n < 380);
			if ($urandom_range(0, 99) < 4)
				send(KIND_SEED, $urandom(), ($urandom_range(0, 3) == 0) ? KEEP_SEED : $urandom());
			else
				send(KIND_DRAW, pick_bound(), $urandom());
		end
		rest();
		calm = 0;
		wait_cycles = 0;
		while (pending != 0 && wait_cycles < 200000) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (3000) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	initial begin
		#20ms;
		$display("FAILURE");
		$finish;
	end
endmodule
